@@ hdl/kmsd_pkg.sv @@
// kmsd_pkg: shared types, codes and reset values for the keypad matrix scanner
// no dependencies; imported by key_matrix_scan_debounce
`default_nettype none

package kmsd_pkg;

  // scan phase encoding (3-bit state register)
  typedef enum logic [2:0] {
    PH_SETTLE0 = 3'd0,
    PH_DEB0    = 3'd1,
    PH_SETTLE1 = 3'd2,
    PH_DEB1    = 3'd3
  } scan_phase_t;

  // configuration register indexes
  typedef enum logic {
    REG_SETTLE   = 1'b0,
    REG_DEBOUNCE = 1'b1
  } cfg_reg_t;

  localparam int SETTLE_W   = 24;
  localparam int DEBOUNCE_W = 16;
  localparam int CFG_W      = 24;
  localparam int COLS_W     = 4;
  localparam int CODE_W     = 4;

  localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = 24'h100000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd1000;

  localparam logic [COLS_W-1:0] COLS_IDLE = 4'hf;

  localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;
  localparam logic [CODE_W-1:0] CODE_PUSH = 4'd9;
  localparam logic [CODE_W-1:0] ROW1_BASE = 4'd4;

  // 1-based index of the lowest low column, 0 when all columns are high
  function automatic logic [CODE_W-1:0] lowest_low_col(input logic [COLS_W-1:0] cols);
    logic [CODE_W-1:0] code;
    code = CODE_NONE;
    for (int b = COLS_W - 1; b >= 0; b--) begin
      if (!cols[b]) begin
        code = CODE_W'(b + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hdl/key_matrix_scan_debounce.sv @@
// key_matrix_scan_debounce: two-row keypad scanner with settle delay and debounce
// depends on kmsd_pkg (phase type, codes, reset values, column encoder)
//
//   channel  direction  beat contents                    handshake
//   in       sink       col_levels, push_level           in_valid / in_stall
//   out      source     drive_row, key_code, scan_done   out_valid / out_stall
//   cfg      sink       cfg_index, cfg_data              cfg_we (no wait)
//
// one result beat per input beat; one beat enters every cycle while in_stall is low,
// its result is registered and shows on out the cycle after it was taken
// the scan state and the result register load in the same cycle as the input beat
// in_stall is high only while a result is held and out_stall is high
// rst (synchronous) restarts the scan on row 0 and restores register defaults
`default_nettype none

module key_matrix_scan_debounce
  import kmsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input beats
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [COLS_W-1:0] col_levels,
  input  wire logic              push_level,
  // result beats
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              drive_row,
  output      logic [CODE_W-1:0] key_code,
  output      logic              scan_done,
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // configuration registers
  logic [SETTLE_W-1:0]   settle_ticks;
  logic [DEBOUNCE_W-1:0] debounce_ticks;

  // scan state
  scan_phase_t         scan_phase, scan_phase_next;
  logic [SETTLE_W-1:0] tick_count, tick_count_next;
  logic [COLS_W-1:0]   latched_cols, latched_cols_next;

  // result of the current beat
  logic              res_row;
  logic [CODE_W-1:0] res_code;
  logic              res_done;

  logic accept;
  logic out_valid_next;

  // shared decode of the current beat
  logic                settle_wait;
  logic                cols_active;
  logic                cols_match;
  logic [SETTLE_W-1:0] tick_inc;
  logic                deb_zero;
  logic                deb_reached;
  logic [CODE_W-1:0]   row_base;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = out_valid && out_stall;

  assign settle_wait = tick_count < settle_ticks;
  assign cols_active = col_levels != COLS_IDLE;
  assign cols_match  = col_levels == latched_cols;
  assign tick_inc    = tick_count + SETTLE_W'(1);
  assign deb_zero    = debounce_ticks == '0;
  assign deb_reached = tick_inc >= SETTLE_W'(debounce_ticks);
  assign row_base    = res_row ? ROW1_BASE : CODE_NONE;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks   <= SETTLE_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETTLE:   settle_ticks   <= cfg_data[SETTLE_W-1:0];
        REG_DEBOUNCE: debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
        default:      ;
      endcase
    end
  end

  // result outputs of the current beat
  always_comb begin
    res_row  = 1'b0;
    res_code = CODE_NONE;
    res_done = 1'b0;
    unique case (scan_phase)
      PH_SETTLE0, PH_SETTLE1: begin
        res_row = scan_phase == PH_SETTLE1;
        if (!settle_wait) begin
          if (!res_row && !push_level) begin
            res_done = 1'b1;
            res_code = CODE_PUSH;
          end else if (cols_active) begin
            if (deb_zero) begin
              res_done = 1'b1;
              res_code = lowest_low_col(col_levels) + row_base;
            end
          end else if (res_row) begin
            res_done = 1'b1;
          end
        end
      end
      PH_DEB0, PH_DEB1: begin
        res_row = scan_phase == PH_DEB1;
        if (!cols_match) begin
          res_done = 1'b1;
        end else if (deb_reached) begin
          res_done = 1'b1;
          res_code = lowest_low_col(latched_cols) + row_base;
        end
      end
      default: ;
    endcase
  end

  // next scan state
  always_comb begin
    scan_phase_next   = scan_phase;
    tick_count_next   = tick_count;
    latched_cols_next = latched_cols;
    unique case (scan_phase)
      PH_SETTLE0, PH_SETTLE1: begin
        if (settle_wait) begin
          tick_count_next = tick_inc;
        end else if (cols_active && !(scan_phase == PH_SETTLE0 && !push_level)) begin
          latched_cols_next = col_levels;
          tick_count_next   = '0;
          scan_phase_next   = (scan_phase == PH_SETTLE0) ? PH_DEB0 : PH_DEB1;
        end else if (scan_phase == PH_SETTLE0 && push_level) begin
          scan_phase_next = PH_SETTLE1;
          tick_count_next = '0;
        end
      end
      PH_DEB0, PH_DEB1: begin
        if (cols_match) begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        scan_phase_next   = PH_SETTLE0;
        tick_count_next   = '0;
        latched_cols_next = COLS_IDLE;
      end
    endcase
    // end of scan restarts on row 0
    if (res_done) begin
      scan_phase_next   = PH_SETTLE0;
      tick_count_next   = '0;
      latched_cols_next = COLS_IDLE;
    end
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase   <= PH_SETTLE0;
      tick_count   <= '0;
      latched_cols <= COLS_IDLE;
    end else if (accept) begin
      scan_phase   <= scan_phase_next;
      tick_count   <= tick_count_next;
      latched_cols <= latched_cols_next;
    end
  end

  // result register
  assign out_valid_next = accept || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_row <= res_row;
      key_code  <= res_code;
      scan_done <= res_done;
    end
  end

  // a finished scan leaves the state at a fresh row 0 settle
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && res_done |=> scan_phase == PH_SETTLE0 && tick_count == '0
                           && latched_cols == COLS_IDLE)
    else $error("scan did not restart after a finished scan");

  // no key code without scan_done
  a_code_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !scan_done |-> key_code == CODE_NONE)
    else $error("key code shown on a beat that does not end a scan");

  // codes never exceed the push code
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code <= CODE_PUSH)
    else $error("key code out of range");

  // debounce phases always hold a latched non-idle pattern
  a_latched: assert property (@(posedge clk) disable iff (rst)
    scan_phase == PH_DEB0 || scan_phase == PH_DEB1 |-> latched_cols != COLS_IDLE)
    else $error("debounce phase with idle latched pattern");

  // input is held off only by a held result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

`default_nettype wire
